/* hdl/i2c_master_bit_sequencer_core_assert.svh */
// assertion helpers shared by the i2c master sequencer rtl
`ifndef I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define I2CM_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("i2cm same-cycle check failed");

// next-cycle implication, checked out of reset
`define I2CM_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("i2cm next-cycle check failed");

`endif

/* hdl/i2cm_pkg.sv */
package i2cm_pkg;

  localparam int unsigned CfgWidth = 16;
  localparam int unsigned CmdWidth = 3;
  localparam int unsigned IdxWidth = 3;

  localparam logic [CmdWidth-1:0] CMD_NONE  = 3'd0;
  localparam logic [CmdWidth-1:0] CMD_INIT  = 3'd1;
  localparam logic [CmdWidth-1:0] CMD_START = 3'd2;
  localparam logic [CmdWidth-1:0] CMD_STOP  = 3'd3;
  localparam logic [CmdWidth-1:0] CMD_WRITE = 3'd4;
  localparam logic [CmdWidth-1:0] CMD_READ  = 3'd5;

  localparam logic [IdxWidth-1:0] CFG_LOW_TIME   = 3'd0;
  localparam logic [IdxWidth-1:0] CFG_HIGH_TIME  = 3'd1;
  localparam logic [IdxWidth-1:0] CFG_START_TIME = 3'd2;
  localparam logic [IdxWidth-1:0] CFG_STOP_TIME  = 3'd3;
  localparam logic [IdxWidth-1:0] CFG_FREE_TIME  = 3'd4;

  localparam logic [CfgWidth-1:0] LOW_TIME_RST   = 16'd100;
  localparam logic [CfgWidth-1:0] HIGH_TIME_RST  = 16'd50;
  localparam logic [CfgWidth-1:0] START_TIME_RST = 16'd50;
  localparam logic [CfgWidth-1:0] STOP_TIME_RST  = 16'd50;
  localparam logic [CfgWidth-1:0] FREE_TIME_RST  = 16'd100;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [14:0] {
    PH_IDLE     = 15'b000000000000001,
    PH_W_HIGH   = 15'b000000000000010,
    PH_W_POLL   = 15'b000000000000100,
    PH_SA_SETUP = 15'b000000000001000,
    PH_SA_HOLD  = 15'b000000000010000,
    PH_SO_SETUP = 15'b000000000100000,
    PH_SO_FREE  = 15'b000000001000000,
    PH_WR_LOW   = 15'b000000010000000,
    PH_WR_HIGH  = 15'b000000100000000,
    PH_WA_LOW   = 15'b000001000000000,
    PH_WA_HIGH  = 15'b000010000000000,
    PH_RD_LOW   = 15'b000100000000000,
    PH_RD_HIGH  = 15'b001000000000000,
    PH_RA_LOW   = 15'b010000000000000,
    PH_RA_HIGH  = 15'b100000000000000
  } phase_t;

  typedef struct packed {
    logic [CfgWidth-1:0] low_time;
    logic [CfgWidth-1:0] high_time;
    logic [CfgWidth-1:0] start_setup_time;
    logic [CfgWidth-1:0] stop_setup_time;
    logic [CfgWidth-1:0] bus_free_time;
  } cfg_t;

  typedef struct packed {
    logic scl_oe;
    logic scl_out;
    logic sda_oe;
    logic sda_out;
  } pins_t;

  typedef struct packed {
    phase_t              phase;
    logic [CmdWidth-1:0] active_cmd;
    logic [3:0]          bit_count;
    logic [7:0]          shift_byte;
    logic                ack_to_send;
    pins_t               pins;
    logic [7:0]          received_byte;
    logic                ack_flag;
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic dropped;
  } status_t;

  localparam pins_t PINS_RELEASED = '{scl_oe: 1'b0, scl_out: 1'b1, sda_oe: 1'b0, sda_out: 1'b1};

  localparam seq_state_t SEQ_RESET = '{
    phase:         PH_IDLE,
    active_cmd:    CMD_NONE,
    bit_count:     4'd0,
    shift_byte:    8'd0,
    ack_to_send:   1'b0,
    pins:          PINS_RELEASED,
    received_byte: 8'd0,
    ack_flag:      1'b0
  };

endpackage

/* hdl/i2cm_cfg.sv */
module i2cm_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [i2cm_pkg::IdxWidth-1:0]       cfg_index,
  input  logic [i2cm_pkg::CfgWidth-1:0]       cfg_wdata,
  output i2cm_pkg::cfg_t                      cfg
);

  i2cm_pkg::cfg_t cfg_r;
  i2cm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        i2cm_pkg::CFG_LOW_TIME:   cfg_nxt.low_time         = cfg_wdata;
        i2cm_pkg::CFG_HIGH_TIME:  cfg_nxt.high_time        = cfg_wdata;
        i2cm_pkg::CFG_START_TIME: cfg_nxt.start_setup_time = cfg_wdata;
        i2cm_pkg::CFG_STOP_TIME:  cfg_nxt.stop_setup_time  = cfg_wdata;
        i2cm_pkg::CFG_FREE_TIME:  cfg_nxt.bus_free_time    = cfg_wdata;
        default: ; // indexes past the register list are ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_time         <= i2cm_pkg::LOW_TIME_RST;
      cfg_r.high_time        <= i2cm_pkg::HIGH_TIME_RST;
      cfg_r.start_setup_time <= i2cm_pkg::START_TIME_RST;
      cfg_r.stop_setup_time  <= i2cm_pkg::STOP_TIME_RST;
      cfg_r.bus_free_time    <= i2cm_pkg::FREE_TIME_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/i2cm_step.sv */
module i2cm_step #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  i2cm_pkg::seq_state_t                st,
  input  logic [DELAY_WIDTH-1:0]              dly,
  input  i2cm_pkg::cfg_t                      cfg,
  input  logic [i2cm_pkg::CmdWidth-1:0]       in_cmd,
  input  logic [7:0]                          in_write_byte,
  input  logic                                in_send_ack,
  input  logic                                in_scl_in,
  input  logic                                in_sda_in,
  output i2cm_pkg::seq_state_t                st_nxt,
  output logic [DELAY_WIDTH-1:0]              dly_nxt,
  output i2cm_pkg::status_t                   status
);

  localparam logic [DELAY_WIDTH-1:0] DlyOne = {{(DELAY_WIDTH-1){1'b0}}, 1'b1};

  // delay registers are 16 bits; the counter may be narrower or wider
  function automatic logic [DELAY_WIDTH-1:0] fit(input logic [i2cm_pkg::CfgWidth-1:0] v);
    logic [DELAY_WIDTH+i2cm_pkg::CfgWidth-1:0] wide;
    wide = {{DELAY_WIDTH{1'b0}}, v};
    return wide[DELAY_WIDTH-1:0];
  endfunction

  logic       cmd_ok;
  logic [3:0] bc_inc;
  logic [7:0] wr_shift;
  logic [7:0] rd_shift;

  assign cmd_ok   = (in_cmd >= i2cm_pkg::CMD_INIT) && (in_cmd <= i2cm_pkg::CMD_READ);
  assign bc_inc   = st.bit_count + 4'd1;
  assign wr_shift = {st.shift_byte[6:0], 1'b0};
  assign rd_shift = {st.shift_byte[6:0], in_sda_in};

  always_comb begin
    st_nxt         = st;
    dly_nxt        = dly;
    status.busy    = 1'b0;
    status.done    = 1'b0;
    status.dropped = 1'b0;
    if (st.phase != i2cm_pkg::PH_IDLE) begin
      status.dropped = cmd_ok;
      if (st.phase != i2cm_pkg::PH_W_POLL && dly > DlyOne) begin
        dly_nxt = dly - DlyOne;
      end else begin
        unique case (st.phase) inside
          i2cm_pkg::PH_W_HIGH, i2cm_pkg::PH_W_POLL: begin
            st_nxt.phase = i2cm_pkg::PH_W_POLL;
            // scl released and seen high: drive it and go on this same tick
            if (in_scl_in) begin
              st_nxt.pins.scl_oe = 1'b1;
              st_nxt.pins.sda_oe = 1'b1;
              if (st.active_cmd == i2cm_pkg::CMD_INIT) begin
                st_nxt.pins.sda_out = 1'b0;
                st_nxt.pins.scl_out = 1'b1;
                dly_nxt             = fit(cfg.stop_setup_time);
                st_nxt.phase        = i2cm_pkg::PH_SO_SETUP;
              end else begin
                st_nxt.pins.sda_out = 1'b1;
                dly_nxt             = fit(cfg.start_setup_time);
                st_nxt.phase        = i2cm_pkg::PH_SA_SETUP;
              end
            end
          end
          i2cm_pkg::PH_SA_SETUP: begin
            st_nxt.pins.sda_out = 1'b0;
            dly_nxt             = fit(cfg.start_setup_time);
            st_nxt.phase        = i2cm_pkg::PH_SA_HOLD;
          end
          i2cm_pkg::PH_SA_HOLD: begin
            st_nxt.pins.scl_out = 1'b0;
            st_nxt.phase        = i2cm_pkg::PH_IDLE;
            status.done         = 1'b1;
          end
          i2cm_pkg::PH_SO_SETUP: begin
            st_nxt.pins.sda_out = 1'b1;
            dly_nxt             = fit(cfg.bus_free_time);
            st_nxt.phase        = i2cm_pkg::PH_SO_FREE;
          end
          i2cm_pkg::PH_WR_LOW, i2cm_pkg::PH_WA_LOW: begin
            st_nxt.pins.scl_out = 1'b1;
            dly_nxt             = fit(cfg.high_time);
            st_nxt.phase        = (st.phase == i2cm_pkg::PH_WR_LOW) ?
                                  i2cm_pkg::PH_WR_HIGH : i2cm_pkg::PH_WA_HIGH;
          end
          i2cm_pkg::PH_WR_HIGH: begin
            st_nxt.pins.scl_out = 1'b0;
            st_nxt.bit_count    = bc_inc;
            st_nxt.shift_byte   = wr_shift;
            dly_nxt             = fit(cfg.low_time);
            if (bc_inc < i2cm_pkg::BITS_PER_BYTE) begin
              st_nxt.pins.sda_out = wr_shift[7];
              st_nxt.phase        = i2cm_pkg::PH_WR_LOW;
            end else begin
              // release sda for the slave ack
              st_nxt.pins.sda_oe  = 1'b0;
              st_nxt.pins.sda_out = 1'b1;
              st_nxt.phase        = i2cm_pkg::PH_WA_LOW;
            end
          end
          i2cm_pkg::PH_WA_HIGH: begin
            st_nxt.ack_flag     = ~in_sda_in;
            st_nxt.pins.scl_out = 1'b0;
            st_nxt.phase        = i2cm_pkg::PH_IDLE;
            status.done         = 1'b1;
          end
          i2cm_pkg::PH_RD_LOW: begin
            st_nxt.pins.scl_out = 1'b1;
            dly_nxt             = fit(cfg.high_time);
            st_nxt.phase        = i2cm_pkg::PH_RD_HIGH;
          end
          i2cm_pkg::PH_RD_HIGH: begin
            st_nxt.shift_byte   = rd_shift;
            st_nxt.pins.scl_out = 1'b0;
            st_nxt.bit_count    = bc_inc;
            dly_nxt             = fit(cfg.low_time);
            if (bc_inc < i2cm_pkg::BITS_PER_BYTE) begin
              st_nxt.phase = i2cm_pkg::PH_RD_LOW;
            end else begin
              st_nxt.pins.sda_out = ~st.ack_to_send;
              st_nxt.phase        = i2cm_pkg::PH_RA_LOW;
            end
          end
          i2cm_pkg::PH_RA_LOW: begin
            st_nxt.pins.sda_oe  = 1'b1;
            st_nxt.pins.scl_out = 1'b1;
            dly_nxt             = fit(cfg.high_time);
            st_nxt.phase        = i2cm_pkg::PH_RA_HIGH;
          end
          i2cm_pkg::PH_RA_HIGH: begin
            st_nxt.pins.scl_out  = 1'b0;
            st_nxt.received_byte = st.shift_byte;
            st_nxt.phase         = i2cm_pkg::PH_IDLE;
            status.done          = 1'b1;
          end
          default: begin
            // end of bus free time, or a phase code that cannot occur
            st_nxt.phase = i2cm_pkg::PH_IDLE;
            status.done  = 1'b1;
          end
        endcase
      end
    end else if (cmd_ok) begin
      st_nxt.active_cmd = in_cmd;
      unique case (in_cmd) inside
        i2cm_pkg::CMD_INIT, i2cm_pkg::CMD_START: begin
          st_nxt.pins.scl_oe  = 1'b0;
          st_nxt.pins.scl_out = 1'b1;
          dly_nxt             = fit(cfg.high_time);
          st_nxt.phase        = i2cm_pkg::PH_W_HIGH;
        end
        i2cm_pkg::CMD_STOP: begin
          st_nxt.pins.sda_oe  = 1'b1;
          st_nxt.pins.sda_out = 1'b0;
          st_nxt.pins.scl_out = 1'b1;
          dly_nxt             = fit(cfg.stop_setup_time);
          st_nxt.phase        = i2cm_pkg::PH_SO_SETUP;
        end
        i2cm_pkg::CMD_WRITE: begin
          st_nxt.shift_byte   = in_write_byte;
          st_nxt.bit_count    = 4'd0;
          st_nxt.pins.sda_oe  = 1'b1;
          st_nxt.pins.sda_out = in_write_byte[7];
          dly_nxt             = fit(cfg.low_time);
          st_nxt.phase        = i2cm_pkg::PH_WR_LOW;
        end
        default: begin
          st_nxt.ack_to_send  = in_send_ack;
          st_nxt.shift_byte   = 8'd0;
          st_nxt.bit_count    = 4'd0;
          st_nxt.pins.sda_oe  = 1'b0;
          st_nxt.pins.sda_out = 1'b1;
          dly_nxt             = fit(cfg.low_time);
          st_nxt.phase        = i2cm_pkg::PH_RD_LOW;
        end
      endcase
    end
    status.busy = (st_nxt.phase != i2cm_pkg::PH_IDLE);
  end

endmodule

/* hdl/i2c_master_bit_sequencer_core.sv */
// sequencer state and output register load on the same edge; an accepted input transfer has
// its result in the output register next cycle; throughput: 1 transfer per cycle as long as
// an input transfer is taken, i.e. whenever the output register is empty or being drained
// reset: rst_n synchronous, active low; phase idle, pins released, delay registers back to
// their defaults, output register empty
`include "i2c_master_bit_sequencer_core_assert.svh"

module i2c_master_bit_sequencer_core #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [i2cm_pkg::IdxWidth-1:0]       cfg_index,
  input  logic [i2cm_pkg::CfgWidth-1:0]       cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [i2cm_pkg::CmdWidth-1:0]       in_cmd,
  input  logic [7:0]                          in_write_byte,
  input  logic                                in_send_ack,
  input  logic                                in_scl_in,
  input  logic                                in_sda_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_scl_oe,
  output logic                                out_scl_out,
  output logic                                out_sda_oe,
  output logic                                out_sda_out,
  output logic                                out_busy_res,
  output logic                                out_done_res,
  output logic [7:0]                          out_read_byte,
  output logic                                out_ack_received,
  output logic                                out_cmd_dropped
);

  localparam logic [DELAY_WIDTH-1:0] DlyOne = {{(DELAY_WIDTH-1){1'b0}}, 1'b1};

  i2cm_pkg::cfg_t       cfg;
  i2cm_pkg::seq_state_t st_r;
  i2cm_pkg::seq_state_t st_nxt;
  logic [DELAY_WIDTH-1:0] delay_r;
  logic [DELAY_WIDTH-1:0] delay_nxt;
  i2cm_pkg::status_t    status;
  logic                 in_fire;
  logic                 dly_counting;

  logic                 out_valid_r;
  i2cm_pkg::pins_t      out_pins_r;
  i2cm_pkg::status_t    out_status_r;
  logic [7:0]           out_read_byte_r;
  logic                 out_ack_r;

  i2cm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  i2cm_step #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_step (
    .st            (st_r),
    .dly           (delay_r),
    .cfg           (cfg),
    .in_cmd        (in_cmd),
    .in_write_byte (in_write_byte),
    .in_send_ack   (in_send_ack),
    .in_scl_in     (in_scl_in),
    .in_sda_in     (in_sda_in),
    .st_nxt        (st_nxt),
    .dly_nxt       (delay_nxt),
    .status        (status)
  );

  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= i2cm_pkg::SEQ_RESET;
      delay_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r    <= st_nxt;
        delay_r <= delay_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each input transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_pins_r      <= st_nxt.pins;
      out_status_r    <= status;
      out_read_byte_r <= st_nxt.received_byte;
      out_ack_r       <= st_nxt.ack_flag;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scl_oe       = out_pins_r.scl_oe;
  assign out_scl_out      = out_pins_r.scl_out;
  assign out_sda_oe       = out_pins_r.sda_oe;
  assign out_sda_out      = out_pins_r.sda_out;
  assign out_busy_res     = out_status_r.busy;
  assign out_done_res     = out_status_r.done;
  assign out_read_byte    = out_read_byte_r;
  assign out_ack_received = out_ack_r;
  assign out_cmd_dropped  = out_status_r.dropped;

  // a transfer that only counts the running phase down
  assign dly_counting = in_fire && (st_r.phase != i2cm_pkg::PH_IDLE) &&
                        (st_r.phase != i2cm_pkg::PH_W_POLL) && (delay_r > DlyOne);

  `I2CM_ASSERT_NOW(a_done_not_busy, out_valid_r && out_done_res, !out_busy_res)
  `I2CM_ASSERT_NOW(a_drop_when_busy, in_fire && status.dropped, st_r.phase != i2cm_pkg::PH_IDLE)
  `I2CM_ASSERT_NOW(a_done_from_busy, in_fire && status.done, st_r.phase != i2cm_pkg::PH_IDLE)
  `I2CM_ASSERT_NEXT(a_hold_no_xfer, rst_n && !in_fire, $stable(st_r) && $stable(delay_r))
  `I2CM_ASSERT_NEXT(a_count_down, rst_n && dly_counting, delay_r == $past(delay_r) - DlyOne)

endmodule
